### hdl/mux_scan_and_coil_pulse_controller_assert.svh
// Assertion macros for the mux scan and coil pulse controller.
// Included by the checker; relies on signals named clock and reset in the including scope.
`ifndef MUX_SCAN_AND_COIL_PULSE_CONTROLLER_ASSERT_SVH
`define MUX_SCAN_AND_COIL_PULSE_CONTROLLER_ASSERT_SVH

// Checked only outside reset.
`define MSCP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSCP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/mscp_pkg.sv
// Shared types and constants for the mux scan and coil pulse controller.
// No dependencies; every other file but the assertion macro header imports this package.
package mscp_pkg;

   localparam int NUM_CHANNELS = 15;
   localparam int ADDR_LINES   = 4;

   localparam int ADDR_W    = 4;
   localparam int CHAN_W    = 8;
   localparam int TICK_W    = 16;
   localparam int SETTLE_W  = 8;
   localparam int SIDX_W    = 4;
   localparam int MAP_W     = NUM_CHANNELS;
   localparam int MAP_OUT_W = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [ADDR_W-1:0]   ADDR_MASK    = ADDR_W'((1 << ADDR_LINES) - 1);
   localparam logic [TICK_W-1:0]   PULSE_RESET  = TICK_W'(2000);
   localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(1);
   localparam logic [TICK_W-1:0]   IDLE_RESET   = TICK_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDR_INVERT   = 3'd0,
      CSR_POWER_INVERT  = 3'd1,
      CSR_LATCH_INVERT  = 3'd2,
      CSR_STATUS_INVERT = 3'd3,
      CSR_PULSE_TICKS   = 3'd4,
      CSR_SETTLE_TICKS  = 3'd5,
      CSR_IDLE_TICKS    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_TOP   = 2'd0,
      PH_PULSE = 2'd1,
      PH_SCAN  = 2'd2,
      PH_IDLE  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr_invert;
      logic                power_invert;
      logic                latch_invert;
      logic                status_invert;
      logic [TICK_W-1:0]   pulse_ticks;
      logic [SETTLE_W-1:0] settle_ticks;
      logic [TICK_W-1:0]   idle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    addr_pins;
      logic                 power_pin;
      logic                 latch_pin;
      logic [MAP_OUT_W-1:0] channel_map;
      logic                 map_changed;
      logic                 pulsing;
   } rsp_type;

endpackage

### hdl/mscp_if.sv
// Channel interfaces of the mux scan and coil pulse controller: tick input,
// result output and register writes. Depends on mscp_pkg.
interface mscp_req_if import mscp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_valid;
   logic [CHAN_W-1:0] req_channel;
   logic              status_pin;

   modport source (output valid, req_valid, req_channel, status_pin, input ready);
   modport sink   (input valid, req_valid, req_channel, status_pin, output ready);
endinterface

interface mscp_rsp_if import mscp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    addr_pins;
   logic                 power_pin;
   logic                 latch_pin;
   logic [MAP_OUT_W-1:0] channel_map;
   logic                 map_changed;
   logic                 pulsing;

   modport source (output valid, addr_pins, power_pin, latch_pin, channel_map,
                   map_changed, pulsing, input ready);
   modport sink   (input valid, addr_pins, power_pin, latch_pin, channel_map,
                   map_changed, pulsing, output ready);
endinterface

interface mscp_csr_if import mscp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   modport source (output valid, csr_index, csr_wdata, input ready);
   modport sink   (input valid, csr_index, csr_wdata, output ready);
endinterface

### hdl/mscp_csr.sv
// Configuration registers of the mux scan and coil pulse controller.
// Depends on mscp_pkg; takes one write beat per cycle.
module mscp_csr import mscp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [CSR_DAT_W-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (csr_index_type'(wr_index))
            CSR_ADDR_INVERT:   cfg_in.addr_invert   = wr_data[ADDR_W-1:0];
            CSR_POWER_INVERT:  cfg_in.power_invert  = wr_data[0];
            CSR_LATCH_INVERT:  cfg_in.latch_invert  = wr_data[0];
            CSR_STATUS_INVERT: cfg_in.status_invert = wr_data[0];
            CSR_PULSE_TICKS:   cfg_in.pulse_ticks   = wr_data[TICK_W-1:0];
            CSR_SETTLE_TICKS:  cfg_in.settle_ticks  = wr_data[SETTLE_W-1:0];
            CSR_IDLE_TICKS:    cfg_in.idle_ticks    = wr_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_invert   <= '0;
         cfg_ff.power_invert  <= 1'b0;
         cfg_ff.latch_invert  <= 1'b0;
         cfg_ff.status_invert <= 1'b0;
         cfg_ff.pulse_ticks   <= PULSE_RESET;
         cfg_ff.settle_ticks  <= SETTLE_RESET;
         cfg_ff.idle_ticks    <= IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/mscp_core.sv
// Tick sequencer: pulse, scan and idle phases, pending request and status maps.
// Depends on mscp_pkg; produces one result per accepted tick.
module mscp_core import mscp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              req_valid,
   input  logic [CHAN_W-1:0] req_channel,
   input  logic              status_pin,
   input  cfg_type           cfg,
   output rsp_type           result
);

   phase_type           phase_ff,   phase_in;
   logic [TICK_W-1:0]   tick_ff,    tick_in;
   logic [SIDX_W-1:0]   idx_ff,     idx_in;
   logic                pend_ff,    pend_in;
   logic [CHAN_W-1:0]   pchan_ff,   pchan_in;
   logic [MAP_W-1:0]    stat_ff,    stat_in;
   logic [MAP_W-1:0]    smap_ff,    smap_in;

   logic                changed;
   logic                do_top;
   logic                do_scan;
   logic                sample;
   logic [TICK_W-1:0]   tick_inc;
   logic [SIDX_W-1:0]   idx_inc;
   logic [MAP_W-1:0]    bit_sel;
   logic [MAP_W-1:0]    map_next;
   logic [SIDX_W-1:0]   addr_chan;
   logic                active;

   // next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      pchan_in = pchan_ff;
      stat_in  = stat_ff;
      smap_in  = smap_ff;
      changed  = 1'b0;
      do_top   = 1'b0;
      do_scan  = 1'b0;
      sample   = status_pin ^ cfg.status_invert;
      tick_inc = tick_ff + TICK_W'(1);
      idx_inc  = idx_ff + SIDX_W'(1);
      bit_sel  = MAP_W'(1) << idx_ff;
      map_next = (smap_ff & ~bit_sel) | (sample ? bit_sel : '0);

      if (fire) begin
         // store the request first so a top-of-loop tick sees it
         if (req_valid) begin
            pend_in  = 1'b1;
            pchan_in = req_channel;
         end

         case (phase_ff)
            PH_TOP: do_top = 1'b1;
            PH_PULSE: begin
               if (tick_ff >= cfg.pulse_ticks) begin
                  do_scan = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_SCAN: begin
               if (tick_inc >= TICK_W'(cfg.settle_ticks)) begin
                  tick_in = '0;
                  smap_in = map_next;
                  if (idx_inc == '0 ||
                      {1'b0, idx_inc} >= (SIDX_W+1)'(NUM_CHANNELS)) begin
                     changed  = (map_next != stat_ff);
                     stat_in  = map_next;
                     idx_in   = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     idx_in = idx_inc;
                  end
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_IDLE: begin
               if (tick_ff >= cfg.idle_ticks) begin
                  do_top = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            default: ;
         endcase

         if (do_top) begin
            pend_in = 1'b0;
            // an out-of-range channel is consumed and dropped
            if (pend_in == 1'b0 && pend_ff == 1'b0 && !req_valid) begin
               do_scan = 1'b1;
            end else if (pchan_in < CHAN_W'(NUM_CHANNELS)) begin
               phase_in = PH_PULSE;
               idx_in   = pchan_in[SIDX_W-1:0];
               tick_in  = TICK_W'(1);
            end else begin
               do_scan = 1'b1;
            end
         end

         if (do_scan) begin
            phase_in = PH_SCAN;
            idx_in   = '0;
            tick_in  = '0;
            smap_in  = stat_ff;
         end
      end
   end

   // result levels after this tick
   always_comb begin
      active    = (phase_in == PH_PULSE);
      addr_chan = (phase_in == PH_PULSE || phase_in == PH_SCAN) ? idx_in : '0;
      result.addr_pins   = (ADDR_W'(addr_chan) ^ cfg.addr_invert) & ADDR_MASK;
      result.power_pin   = active ^ cfg.power_invert;
      result.latch_pin   = active ^ cfg.latch_invert;
      result.channel_map = MAP_OUT_W'(stat_in);
      result.map_changed = changed;
      result.pulsing     = active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOP;
         tick_ff  <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         pchan_ff <= '0;
         stat_ff  <= '0;
         smap_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         pchan_ff <= pchan_in;
         stat_ff  <= stat_in;
         smap_ff  <= smap_in;
      end
   end

endmodule

### hdl/mscp_skid.sv
// Two-entry result queue that decouples the sequencer from the result channel.
// Depends on mscp_pkg for the result type.
module mscp_skid import mscp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  rsp_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data
);

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/mux_scan_and_coil_pulse_controller.sv
// Top level of the mux scan and coil pulse controller.
// Depends on mscp_pkg, the channel interfaces, mscp_csr, mscp_core and mscp_skid.
//
// Each input beat is one millisecond tick and yields exactly one result beat.
// A tick is taken in every cycle while the two-entry result queue has room,
// so the sustained rate is one tick per clock; the result for a tick waits
// in the queue behind earlier results. The sequencer does all of one tick's
// counter compare, map update and pin encoding between its state registers
// and the queue, and the queue alone sets back-pressure. Register writes are
// always ready and take effect from the next tick.
module mux_scan_and_coil_pulse_controller import mscp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mscp_req_if.sink    req_bus,
   mscp_rsp_if.source  rsp_bus,
   mscp_csr_if.sink    csr_bus
);

   cfg_type cfg;
   rsp_type core_result;
   rsp_type out_data;
   logic    fire;
   logic    q_ready;

   assign req_bus.ready = q_ready;
   assign fire          = req_bus.valid && q_ready;

   mscp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.csr_index),
      .wr_data  (csr_bus.csr_wdata),
      .cfg      (cfg)
   );

   mscp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .req_valid   (req_bus.req_valid),
      .req_channel (req_bus.req_channel),
      .status_pin  (req_bus.status_pin),
      .cfg         (cfg),
      .result      (core_result)
   );

   mscp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fire),
      .push_ready (q_ready),
      .push_data  (core_result),
      .pop_valid  (rsp_bus.valid),
      .pop_ready  (rsp_bus.ready),
      .pop_data   (out_data)
   );

   assign rsp_bus.addr_pins   = out_data.addr_pins;
   assign rsp_bus.power_pin   = out_data.power_pin;
   assign rsp_bus.latch_pin   = out_data.latch_pin;
   assign rsp_bus.channel_map = out_data.channel_map;
   assign rsp_bus.map_changed = out_data.map_changed;
   assign rsp_bus.pulsing     = out_data.pulsing;

endmodule

### hdl/mscp_checker.sv
// Port-level checks for the mux scan and coil pulse controller, bound to the top level.
// Depends on mscp_pkg and the assertion macro header.
`include "mux_scan_and_coil_pulse_controller_assert.svh"

module mscp_checker import mscp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ADDR_W-1:0]    rsp_addr_pins,
   input logic                 rsp_power_pin,
   input logic                 rsp_latch_pin,
   input logic [MAP_OUT_W-1:0] rsp_channel_map,
   input logic                 rsp_map_changed,
   input logic                 rsp_pulsing
);

   // the queue is empty after reset
   `MSCP_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid, "result offered after reset")

   // back-pressure only when the queue holds results
   `MSCP_ASSERT(a_stall_needs_backlog, !req_ready |-> rsp_valid, "input stalled with empty queue")

   // a scan finishes in the idle phase, never during a pulse
   `MSCP_ASSERT(a_change_not_pulsing, (rsp_valid && rsp_map_changed) |-> !rsp_pulsing,
                "map change flagged during a pulse")

   // hold a stalled result beat
   `MSCP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid &&
                $stable({rsp_addr_pins, rsp_power_pin, rsp_latch_pin, rsp_channel_map,
                         rsp_map_changed, rsp_pulsing})), "stalled result beat changed")

endmodule

bind mux_scan_and_coil_pulse_controller mscp_checker u_mscp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_addr_pins   (rsp_bus.addr_pins),
   .rsp_power_pin   (rsp_bus.power_pin),
   .rsp_latch_pin   (rsp_bus.latch_pin),
   .rsp_channel_map (rsp_bus.channel_map),
   .rsp_map_changed (rsp_bus.map_changed),
   .rsp_pulsing     (rsp_bus.pulsing)
);
